>>> sv/ued_pkg.sv
// ----------------------------------------------------------------------------
// ued_pkg
// Shared types, character codes and the hex digit decode for the unicode
// escape decoder.
// ----------------------------------------------------------------------------
package ued_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] LAST_DIGIT = 2'd3;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_SLASH  = 2'd1,
    PH_URUN   = 2'd2,
    PH_HEX    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       esc;
    logic       bad;
  } result_t;

  // one queue entry: the results of one byte
  typedef struct packed {
    result_t    res0;
    logic       dual;
    logic [7:0] ch1;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hexdig_t;

  function automatic hexdig_t hex_decode(input logic [7:0] b);
    hexdig_t    h;
    logic [7:0] t;
    h = '0;
    t = '0;
    if (b >= CH_0 && b <= CH_9) begin
      t     = b - CH_0;
      h.ok  = 1'b1;
      h.nib = t[3:0];
    end else if (b >= CH_LA && b <= CH_LF) begin
      t     = b - CH_LA + HEX_TEN;
      h.ok  = 1'b1;
      h.nib = t[3:0];
    end else if (b >= CH_UA && b <= CH_UF) begin
      t     = b - CH_UA + HEX_TEN;
      h.ok  = 1'b1;
      h.nib = t[3:0];
    end
    return h;
  endfunction

endpackage

>>> sv/ued_if.sv
// ----------------------------------------------------------------------------
// ued_in_if / ued_out_if
// Valid/ready channels for source bytes and decoded characters.
// ----------------------------------------------------------------------------
interface ued_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_mark;

  modport source (output valid, output data_byte, output end_mark, input ready);
  modport sink   (input valid, input data_byte, input end_mark, output ready);
endinterface

interface ued_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       from_escape;
  logic       bad_escape;
  logic       last_out;

  modport source (output valid, output out_char, output from_escape,
                  output bad_escape, output last_out, input ready);
  modport sink   (input valid, input out_char, input from_escape,
                  input bad_escape, input last_out, output ready);
endinterface

>>> sv/unicode_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// unicode_escape_decoder_core
// Turns raw source bytes into the lexer character stream, decoding
// backslash-u escapes and flagging malformed ones.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                      | handshake
//  in_chan   | in  | data_byte[7:0], end_mark                     | valid/ready
//  out_chan  | out | out_char[7:0], from_escape, bad_escape,      | valid/ready
//            |     | last_out                                     |
//
//  one byte is taken per cycle while the four-entry result queue has room
//  a byte that gives two items (backslash then a plain byte) fills the
//  output register twice, and its entry stays at the queue head until both
//  are loaded; bytes inside an escape give no item until the escape ends
//  each item passes through the result queue and then the output register
//  synchronous active-low reset puts the scanner in normal mode, queue empty
// ----------------------------------------------------------------------------
module unicode_escape_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  ued_in_if.sink     in_chan,
  ued_out_if.source  out_chan
);
  import ued_pkg::*;

  logic   push, pop, q_full, q_empty;
  entry_t push_entry, head;

  // front part: escape scanner, one byte per cycle while the queue has room
  ued_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue of per-byte results
  ued_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  // back part: unpacks entries into items in the output register
  ued_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // the scanner never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full queue");

  // the last byte of the input always yields at least one item
  a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.end_mark) |-> push)
    else $error("final byte produced no item");

  // an error item carries no character and no escape flag
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.bad_escape) |->
      (out_chan.out_char == 8'd0 && !out_chan.from_escape))
    else $error("malformed error item");

  // the back part never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

>>> sv/ued_front.sv
// ----------------------------------------------------------------------------
// ued_front
// Escape scanner: takes one byte per cycle while the queue is not full and pushes its results.
// ----------------------------------------------------------------------------
module ued_front (
  input  logic            clk,
  input  logic            rst_n,
  ued_in_if.sink          in_chan,
  input  logic            q_full,
  output logic            push,
  output ued_pkg::entry_t push_entry
);
  import ued_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] acc_r, acc_nxt;

  logic       acc_in;
  logic [7:0] b;
  logic       last;
  hexdig_t    hd;
  logic [7:0] acc_shift;
  logic       is_bs, is_u;

  assign in_chan.ready = !q_full;
  assign acc_in    = in_chan.valid && !q_full;
  assign b         = in_chan.data_byte;
  assign last      = in_chan.end_mark;
  assign hd        = hex_decode(b);
  assign acc_shift = {acc_r[3:0], hd.nib};
  assign is_bs     = (b == CH_BSLASH);
  assign is_u      = (b == CH_U);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    case (phase_r)
      PH_NORMAL: begin
        if (is_bs && !last) phase_nxt = PH_SLASH;
      end
      PH_SLASH: begin
        if (is_u) begin
          phase_nxt = last ? PH_NORMAL : PH_URUN;
        end else if (is_bs && !last) begin
          phase_nxt = PH_SLASH;
        end else begin
          phase_nxt = PH_NORMAL;
        end
      end
      PH_URUN: begin
        if (is_u && !last) begin
          phase_nxt = PH_URUN;
        end else if (!hd.ok || last) begin
          phase_nxt = PH_NORMAL;
        end else begin
          phase_nxt = PH_HEX;
          acc_nxt   = {4'd0, hd.nib};
          cnt_nxt   = 2'd1;
        end
      end
      PH_HEX: begin
        if (!hd.ok || cnt_r == LAST_DIGIT || last) begin
          phase_nxt = PH_NORMAL;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
          acc_nxt = acc_shift;
        end
      end
      default: phase_nxt = PH_NORMAL;
    endcase
    if (phase_nxt == PH_NORMAL) begin
      cnt_nxt = '0;
      acc_nxt = '0;
    end
  end

  // outputs
  always_comb begin
    logic    emit;
    result_t err;
    emit       = 1'b0;
    err        = '{ch: 8'd0, esc: 1'b0, bad: 1'b1};
    push_entry = '0;
    push_entry.ch1  = b;
    push_entry.last = last;
    case (phase_r)
      PH_NORMAL: begin
        if (!(is_bs && !last)) begin
          emit = 1'b1;
          push_entry.res0 = '{ch: b, esc: 1'b0, bad: 1'b0};
        end
      end
      PH_SLASH: begin
        emit = !(is_u && !last);
        if (is_u) begin
          push_entry.res0 = err;
        end else begin
          push_entry.res0 = '{ch: CH_BSLASH, esc: 1'b0, bad: 1'b0};
          push_entry.dual = !(is_bs && !last);
        end
      end
      PH_URUN: begin
        if (!(is_u && !last) && (!hd.ok || last)) begin
          emit = 1'b1;
          push_entry.res0 = err;
        end
      end
      PH_HEX: begin
        if (!hd.ok) begin
          emit = 1'b1;
          push_entry.res0 = err;
        end else if (cnt_r == LAST_DIGIT) begin
          emit = 1'b1;
          push_entry.res0 = '{ch: acc_shift, esc: 1'b1, bad: 1'b0};
        end else if (last) begin
          emit = 1'b1;
          push_entry.res0 = err;
        end
      end
      default: emit = 1'b0;
    endcase
    push = acc_in && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      cnt_r   <= '0;
      acc_r   <= '0;
    end else if (acc_in) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

>>> sv/ued_queue.sv
// ----------------------------------------------------------------------------
// ued_queue
// Small first-in first-out queue of result entries.
// ----------------------------------------------------------------------------
module ued_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ued_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output ued_pkg::entry_t head
);
  import ued_pkg::*;

  entry_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCW'(1);
    else if (!push && pop) cnt_nxt = cnt_r - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop)  rp_r <= rp_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/ued_back.sv
// ----------------------------------------------------------------------------
// ued_back
// Result emitter: unpacks queue entries into one or two output items.
// ----------------------------------------------------------------------------
module ued_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ued_pkg::entry_t head,
  output logic            pop,
  ued_out_if.source       out_chan
);
  import ued_pkg::*;

  logic       valid_r, valid_nxt;
  logic       sel_r, sel_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       esc_r, esc_nxt;
  logic       bad_r, bad_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    ch_nxt    = ch_r;
    esc_nxt   = esc_r;
    bad_nxt   = bad_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        if (sel_r) begin
          ch_nxt   = head.ch1;
          esc_nxt  = 1'b0;
          bad_nxt  = 1'b0;
          last_nxt = head.last;
          pop      = 1'b1;
          sel_nxt  = 1'b0;
        end else begin
          ch_nxt   = head.res0.ch;
          esc_nxt  = head.res0.esc;
          bad_nxt  = head.res0.bad;
          last_nxt = head.last && !head.dual;
          pop      = !head.dual;
          sel_nxt  = head.dual;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    esc_r  <= esc_nxt;
    bad_r  <= bad_nxt;
    last_r <= last_nxt;
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.out_char    = ch_r;
  assign out_chan.from_escape = esc_r;
  assign out_chan.bad_escape  = bad_r;
  assign out_chan.last_out    = last_r;

endmodule
